// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is high
`define HVN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// clocked check that also holds across reset
`define HVN_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/hvn_pkg.sv =====
package hvn_pkg;

  localparam int FRAC_BITS = 14;

  localparam int HGT_W  = 8;
  localparam int DIFF_W = HGT_W + 1;
  localparam int PQ_W   = DIFF_W + 1;
  localparam int LEN_W  = 2 * PQ_W;

  localparam int FACES = 4;
  localparam int COMPS = 3;
  localparam int COMP_X = 0;
  localparam int COMP_Y = 1;
  localparam int COMP_Z = 2;

  localparam int FACE_Z          = 11;
  localparam int FACE_SQRT_SHIFT = 40;
  localparam int FACE_DIV_SHIFT  = 48;

  // square root recurrence: two radicand bits per step
  localparam int SQ_IN_W   = 62;
  localparam int SQ_ROOT_W = SQ_IN_W / 2;
  localparam int SQ_REM_W  = SQ_ROOT_W + 2;
  localparam int SQ_STEPS  = SQ_ROOT_W;

  // restoring division: one quotient bit per step
  localparam int DIV_Q_W   = 29;
  localparam int DIV_DVS_W = 31;
  localparam int DIV_DVD_W = 2 * DIV_Q_W;
  localparam int DIV_STEPS = DIV_Q_W;

  localparam int SUM_W = 32;
  localparam int MAG_W = SUM_W - 1;
  localparam int NX_W  = 16;
  localparam int NZ_W  = 15;

  localparam int LAT = 2 + SQ_STEPS + 1 + DIV_STEPS + 3 + SQ_STEPS + 1 + DIV_STEPS + 1;

  localparam logic [DIV_Q_W-1:0] ONE_Q = DIV_Q_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic [SQ_IN_W-1:0]   rad;
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic                 neg;
    logic [DIV_DVS_W-1:0] dvs;
    logic [DIV_DVS_W-1:0] rem;
    logic [DIV_Q_W-1:0]   low;
    logic [DIV_Q_W-1:0]   quo;
  } div_t;

  function automatic sq_t sq_init(input logic [SQ_IN_W-1:0] rad);
    sq_t r;
    r.rad  = rad;
    r.rem  = '0;
    r.root = '0;
    return r;
  endfunction

  // upper half of the dividend seeds the remainder, it is below the divisor
  function automatic div_t div_init(input logic [DIV_DVD_W-1:0] dvd,
                                    input logic [DIV_DVS_W-1:0] dvs,
                                    input logic neg);
    div_t r;
    r.neg = neg;
    r.dvs = dvs;
    r.rem = DIV_DVS_W'(dvd[DIV_DVD_W-1:DIV_Q_W]);
    r.low = dvd[DIV_Q_W-1:0];
    r.quo = '0;
    return r;
  endfunction

endpackage

// ===== sv/hvn_ifs.sv =====
interface hvn_in_if import hvn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [HGT_W-1:0] center_height;
  logic signed [HGT_W-1:0] top_height;
  logic signed [HGT_W-1:0] right_height;
  logic signed [HGT_W-1:0] bottom_height;
  logic signed [HGT_W-1:0] left_height;

  modport source (output valid, center_height, top_height, right_height, bottom_height,
                  left_height, input ready);
  modport sink (input valid, center_height, top_height, right_height, bottom_height,
                left_height, output ready);
endinterface

interface hvn_out_if import hvn_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [NX_W-1:0] normal_x;
  logic signed [NX_W-1:0] normal_y;
  logic [NZ_W-1:0]        normal_z;

  modport source (output valid, normal_x, normal_y, normal_z, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, output ready);
endinterface

// ===== sv/hvn_sqrt_stage.sv =====
module hvn_sqrt_stage import hvn_pkg::*; (
  input  logic clk,
  input  logic ce,
  input  sq_t  d,
  output sq_t  q
);

  logic [SQ_REM_W+1:0] t;
  logic [SQ_REM_W+1:0] trial;
  logic                take;
  sq_t                 nx;

  always_comb begin
    t       = {d.rem, d.rad[SQ_IN_W-1 -: 2]};
    trial   = {2'b00, d.root, 2'b01};
    take    = (t >= trial);
    nx.rad  = {d.rad[SQ_IN_W-3:0], 2'b00};
    nx.rem  = take ? SQ_REM_W'(t - trial) : SQ_REM_W'(t);
    nx.root = {d.root[SQ_ROOT_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      q <= nx;
    end
  end

endmodule

// ===== sv/hvn_div_stage.sv =====
module hvn_div_stage import hvn_pkg::*; (
  input  logic clk,
  input  logic ce,
  input  div_t d,
  output div_t q
);

  logic [DIV_DVS_W:0] t;
  logic               take;
  div_t               nx;

  always_comb begin
    t      = {d.rem, d.low[DIV_Q_W-1]};
    take   = (t >= {1'b0, d.dvs});
    nx.neg = d.neg;
    nx.dvs = d.dvs;
    nx.rem = take ? DIV_DVS_W'(t - {1'b0, d.dvs}) : DIV_DVS_W'(t);
    nx.low = {d.low[DIV_Q_W-2:0], 1'b0};
    nx.quo = {d.quo[DIV_Q_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      q <= nx;
    end
  end

endmodule

// ===== sv/heightmap_vertex_normal_unit.sv =====
// throughput: one word per cycle; the whole pipeline advances together and
// holds when the output word is valid and not taken
// the pipeline depth is set by the bit-serial sqrt and divide chains, one step per stage
// reset (synchronous, active high) clears every stage valid bit; data is not reset
`include "assert_macros.svh"

module heightmap_vertex_normal_unit import hvn_pkg::*; (
  input logic       clk,
  input logic       rst,
  hvn_in_if.sink    heights,
  hvn_out_if.source normal
);

  // face order around the vertex
  localparam int FACE_LB = 0;
  localparam int FACE_BR = 1;
  localparam int FACE_RT = 2;
  localparam int FACE_TL = 3;

  // pipeline advance: the output register is free or being emptied
  logic ce;
  assign ce            = !normal.valid || normal.ready;
  assign heights.ready = ce;

  logic [LAT-1:0] vld;
  logic [LAT-2:0] flat;

  // stage 1: neighbour differences and the face slope pairs
  logic signed [DIFF_W-1:0] dt, dr, db, dl;
  logic signed [PQ_W-1:0]   pc [FACES];
  logic signed [PQ_W-1:0]   qc [FACES];
  logic                     flat_in;

  assign dt = heights.top_height    - heights.center_height;
  assign dr = heights.right_height  - heights.center_height;
  assign db = heights.bottom_height - heights.center_height;
  assign dl = heights.left_height   - heights.center_height;
  assign flat_in = (dt == '0) && (dr == '0) && (db == '0) && (dl == '0);

  always_comb begin
    pc[FACE_LB] = dl + db;
    qc[FACE_LB] = dl - db;
    pc[FACE_BR] = db - dr;
    qc[FACE_BR] = -(dr + db);
    pc[FACE_RT] = -(dr + dt);
    qc[FACE_RT] = dt - dr;
    pc[FACE_TL] = dl - dt;
    qc[FACE_TL] = dl + dt;
  end

  // valid and flat travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[LAT-2:0], heights.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      flat <= {flat[LAT-3:0], flat_in};
    end
  end

  logic signed [PQ_W-1:0] p1 [FACES];
  logic signed [PQ_W-1:0] q1 [FACES];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int f = 0; f < FACES; f++) begin
        p1[f] <= pc[f];
        q1[f] <= qc[f];
      end
    end
  end

  // stage 2: squared face length p*p + q*q + 11*11, then its delay line
  logic [LEN_W-1:0]       psq [FACES];
  logic [LEN_W-1:0]       qsq [FACES];
  logic [LEN_W-1:0]       len2 [FACES];
  logic signed [PQ_W-1:0] fp_dly [FACES][SQ_STEPS+1];
  logic signed [PQ_W-1:0] fq_dly [FACES][SQ_STEPS+1];

  always_comb begin
    for (int f = 0; f < FACES; f++) begin
      psq[f] = LEN_W'(p1[f] * p1[f]);
      qsq[f] = LEN_W'(q1[f] * q1[f]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int f = 0; f < FACES; f++) begin
        len2[f]      <= psq[f] + qsq[f] + LEN_W'(FACE_Z * FACE_Z);
        fp_dly[f][0] <= p1[f];
        fq_dly[f][0] <= q1[f];
        for (int k = 1; k <= SQ_STEPS; k++) begin
          fp_dly[f][k] <= fp_dly[f][k-1];
          fq_dly[f][k] <= fq_dly[f][k-1];
        end
      end
    end
  end

  // face length square roots, scaled by 2^20
  sq_t fsq [FACES][SQ_STEPS+1];

  for (genvar f = 0; f < FACES; f++) begin : g_face_sqrt
    assign fsq[f][0] = sq_init(SQ_IN_W'(len2[f]) << FACE_SQRT_SHIFT);
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
      hvn_sqrt_stage u_step (
        .clk (clk),
        .ce  (ce),
        .d   (fsq[f][k]),
        .q   (fsq[f][k+1])
      );
    end
  end

  // stage after sqrt: rounded dividends c * 2^48 + s/2 for each face component
  function automatic logic [PQ_W-1:0] abs_pq(input logic signed [PQ_W-1:0] v);
    return v[PQ_W-1] ? PQ_W'(-v) : PQ_W'(v);
  endfunction

  function automatic logic [DIV_DVD_W-1:0] face_dvd(input logic [PQ_W-1:0] mag,
                                                    input logic [SQ_ROOT_W-1:0] s);
    return (DIV_DVD_W'(mag) << FACE_DIV_SHIFT) + DIV_DVD_W'(s >> 1);
  endfunction

  localparam int FDIVS = FACES * COMPS;

  div_t fdv_in [FDIVS];
  div_t fdv [FDIVS][DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int f = 0; f < FACES; f++) begin
        fdv_in[f*COMPS+COMP_X] <= div_init(
          face_dvd(abs_pq(fp_dly[f][SQ_STEPS]), fsq[f][SQ_STEPS].root),
          DIV_DVS_W'(fsq[f][SQ_STEPS].root), fp_dly[f][SQ_STEPS][PQ_W-1]);
        fdv_in[f*COMPS+COMP_Y] <= div_init(
          face_dvd(abs_pq(fq_dly[f][SQ_STEPS]), fsq[f][SQ_STEPS].root),
          DIV_DVS_W'(fsq[f][SQ_STEPS].root), fq_dly[f][SQ_STEPS][PQ_W-1]);
        fdv_in[f*COMPS+COMP_Z] <= div_init(
          face_dvd(PQ_W'(FACE_Z), fsq[f][SQ_STEPS].root),
          DIV_DVS_W'(fsq[f][SQ_STEPS].root), 1'b0);
      end
    end
  end

  // unit face normals with 28 fraction bits
  for (genvar j = 0; j < FDIVS; j++) begin : g_face_div
    assign fdv[j][0] = fdv_in[j];
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      hvn_div_stage u_step (
        .clk (clk),
        .ce  (ce),
        .d   (fdv[j][k]),
        .q   (fdv[j][k+1])
      );
    end
  end

  // sum of the four unit normals
  logic signed [SUM_W-1:0] s_sum [COMPS];
  logic signed [SUM_W-1:0] s4 [COMPS];

  always_comb begin
    for (int c = 0; c < COMPS; c++) begin
      s_sum[c] = '0;
      for (int f = 0; f < FACES; f++) begin
        s_sum[c] = s_sum[c] + (fdv[f*COMPS+c][DIV_STEPS].neg ?
                               -SUM_W'(fdv[f*COMPS+c][DIV_STEPS].quo) :
                               SUM_W'(fdv[f*COMPS+c][DIV_STEPS].quo));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s4 <= s_sum;
    end
  end

  // magnitudes and their squares
  logic [MAG_W-1:0]   s_mag [COMPS];
  logic [MAG_W-1:0]   s5_mag [COMPS];
  logic               s5_neg [COMPS];
  logic [SQ_IN_W-1:0] s5_sq [COMPS];

  always_comb begin
    for (int c = 0; c < COMPS; c++) begin
      s_mag[c] = s4[c][SUM_W-1] ? MAG_W'(-s4[c]) : MAG_W'(s4[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int c = 0; c < COMPS; c++) begin
        s5_mag[c] <= s_mag[c];
        s5_neg[c] <= s4[c][SUM_W-1];
        s5_sq[c]  <= s_mag[c] * s_mag[c];
      end
    end
  end

  // squared length of the sum and the sign / magnitude delay line
  logic [SQ_IN_W-1:0] m6;
  logic [MAG_W-1:0]   smag_dly [COMPS][SQ_STEPS+1];
  logic               sneg_dly [COMPS][SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (ce) begin
      m6 <= SQ_IN_W'(s5_sq[COMP_X] + s5_sq[COMP_Y] + s5_sq[COMP_Z]);
      for (int c = 0; c < COMPS; c++) begin
        smag_dly[c][0] <= s5_mag[c];
        sneg_dly[c][0] <= s5_neg[c];
        for (int k = 1; k <= SQ_STEPS; k++) begin
          smag_dly[c][k] <= smag_dly[c][k-1];
          sneg_dly[c][k] <= sneg_dly[c][k-1];
        end
      end
    end
  end

  sq_t nsq [SQ_STEPS+1];

  assign nsq[0] = sq_init(m6);

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sum_sqrt
    hvn_sqrt_stage u_step (
      .clk (clk),
      .ce  (ce),
      .d   (nsq[k]),
      .q   (nsq[k+1])
    );
  end

  // final rounded dividends |S| * 2^FRAC_BITS + n/2
  div_t ndv_in [COMPS];
  div_t ndv [COMPS][DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int c = 0; c < COMPS; c++) begin
        ndv_in[c] <= div_init(
          (DIV_DVD_W'(smag_dly[c][SQ_STEPS]) << FRAC_BITS)
            + DIV_DVD_W'(nsq[SQ_STEPS].root >> 1),
          DIV_DVS_W'(nsq[SQ_STEPS].root), sneg_dly[c][SQ_STEPS]);
      end
    end
  end

  for (genvar c = 0; c < COMPS; c++) begin : g_sum_div
    assign ndv[c][0] = ndv_in[c];
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      hvn_div_stage u_step (
        .clk (clk),
        .ce  (ce),
        .d   (ndv[c][k]),
        .q   (ndv[c][k+1])
      );
    end
  end

  // output word: limit to one, restore sign, flat vertex points straight up
  logic [DIV_Q_W-1:0] lim [COMPS];
  logic [DIV_Q_W-1:0] sval [COMPS];

  always_comb begin
    for (int c = 0; c < COMPS; c++) begin
      lim[c]  = (ndv[c][DIV_STEPS].quo > ONE_Q) ? ONE_Q : ndv[c][DIV_STEPS].quo;
      sval[c] = ndv[c][DIV_STEPS].neg ? DIV_Q_W'(-lim[c]) : lim[c];
    end
  end

  assign normal.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (ce) begin
      if (flat[LAT-2]) begin
        normal.normal_x <= '0;
        normal.normal_y <= '0;
        normal.normal_z <= NZ_W'(ONE_Q);
      end else begin
        normal.normal_x <= NX_W'(sval[COMP_X]);
        normal.normal_y <= NX_W'(sval[COMP_Y]);
        normal.normal_z <= NZ_W'(lim[COMP_Z]);
      end
    end
  end

  `HVN_ASSERT_ALWAYS(a_rst_clears, rst |=> !normal.valid, "valid after reset")
  `HVN_ASSERT(a_z_positive, normal.valid |-> normal.normal_z != '0, "zero z component")
  `HVN_ASSERT(a_z_bound, normal.valid |-> normal.normal_z <= NZ_W'(ONE_Q), "z above one")
  `HVN_ASSERT(a_stall_only, !heights.ready |-> normal.valid && !normal.ready, "stall w/o need")

endmodule
